/* sv/assert_macros.svh */
// Assertion macros shared by the RTC calendar RTL.
// Depends on nothing; the including module must have clk_i and rst_ni in scope.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Concurrent check, disabled while reset is asserted
`define RTC_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// Concurrent check that also holds through reset
`define RTC_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) (prop)) else $error(msg);

`endif

/* sv/rtc_cal_pkg.sv */
// Package for the RTC calendar counter: field widths, calendar types,
// constants and small calendar functions. Depends on nothing.
`default_nettype none

package rtc_cal_pkg;

  // Field widths
  localparam int YearW  = 14;
  localparam int MonthW = 4;
  localparam int DayW   = 5;
  localparam int HourW  = 5;
  localparam int MinW   = 6;
  localparam int SecW   = 6;
  localparam int WdayW  = 3;
  localparam int YdayW  = 9;
  localparam int DdW    = YearW + 1;

  // Calendar limits
  localparam int MaxYear    = 9999;
  localparam int LastMonth  = 12;
  localparam int LastHour   = 23;
  localparam int LastMinute = 59;
  localparam int LastSecond = 59;
  localparam int Feb        = 2;
  localparam int Mar        = 3;

  // Reset time and date: 12:00:00 on 1 January 2000
  localparam int ResetYear  = 2000;
  localparam int ResetMonth = 1;
  localparam int ResetDay   = 1;
  localparam int ResetHour  = 12;

  // Division by 100 through a reciprocal: q = (y * 5243) >> 19, exact for 14 bit y
  localparam int Recip100      = 5243;
  localparam int Recip100Shift = 19;
  localparam int Quot100W      = 8;
  localparam int ProdW         = Recip100Shift + Quot100W;

  // Item modes
  localparam logic ModeTick = 1'b0;
  localparam logic ModeLoad = 1'b1;

  typedef logic [YearW-1:0]  year_t;
  typedef logic [MonthW-1:0] month_t;
  typedef logic [DayW-1:0]   day_t;
  typedef logic [HourW-1:0]  hour_t;
  typedef logic [MinW-1:0]   minute_t;
  typedef logic [SecW-1:0]   second_t;
  typedef logic [WdayW-1:0]  wday_t;
  typedef logic [YdayW-1:0]  yday_t;

  typedef struct packed {
    year_t   year;
    month_t  month;
    day_t    day;
    hour_t   hour;
    minute_t minute;
    second_t second;
  } calendar_t;

  // Beat from the counter stage to the derive stages
  typedef struct packed {
    logic      vld;
    logic      refused;
    calendar_t cal;
  } snap_t;

  // Occupancy of a pair of pipeline stages
  typedef struct packed {
    logic head_vld;
    logic tail_vld;
  } stage_stat_t;

  function automatic logic [ProdW-1:0] mul_recip100(year_t y);
    return ProdW'(y) * ProdW'(Recip100);
  endfunction

  // 4/100/400 rule; the low product bits fall below the reciprocal only for multiples of 100
  function automatic logic is_leap(year_t y);
    logic [ProdW-1:0] p;
    logic             div100;
    p      = mul_recip100(y);
    div100 = p[Recip100Shift-1:0] < Recip100Shift'(Recip100);
    return (y[1:0] == 2'b00) && (!div100 || (p[Recip100Shift+1:Recip100Shift] == 2'b00));
  endfunction

  function automatic day_t month_len(month_t m, logic leap);
    day_t len;
    unique case (m)
      4'd2:                      len = leap ? 5'd29 : 5'd28;
      4'd4, 4'd6, 4'd9, 4'd11:   len = 5'd30;
      default:                   len = 5'd31;
    endcase
    return len;
  endfunction

  // Days in the months before m, common year
  function automatic yday_t cum_days(month_t m);
    yday_t d;
    unique case (m)
      4'd2:    d = 9'd31;
      4'd3:    d = 9'd59;
      4'd4:    d = 9'd90;
      4'd5:    d = 9'd120;
      4'd6:    d = 9'd151;
      4'd7:    d = 9'd181;
      4'd8:    d = 9'd212;
      4'd9:    d = 9'd243;
      4'd10:   d = 9'd273;
      4'd11:   d = 9'd304;
      4'd12:   d = 9'd334;
      default: d = 9'd0;
    endcase
    return d;
  endfunction

  // floor(23 * m / 9) for the weekday sum
  function automatic logic [4:0] month_offset(month_t m);
    logic [4:0] o;
    unique case (m)
      4'd1:    o = 5'd2;
      4'd2:    o = 5'd5;
      4'd3:    o = 5'd7;
      4'd4:    o = 5'd10;
      4'd5:    o = 5'd12;
      4'd6:    o = 5'd15;
      4'd7:    o = 5'd17;
      4'd8:    o = 5'd20;
      4'd9:    o = 5'd23;
      4'd10:   o = 5'd25;
      4'd11:   o = 5'd28;
      4'd12:   o = 5'd30;
      default: o = 5'd0;
    endcase
    return o;
  endfunction

endpackage

`default_nettype wire

/* sv/rtc_cal_if.sv */
// Valid/ready channel interfaces for the RTC calendar counter.
// Depends on rtc_cal_pkg for the field types.
`default_nettype none

interface rtc_cal_in_if;
  logic                valid;
  logic                ready;
  logic                mode;
  rtc_cal_pkg::year_t   set_year;
  rtc_cal_pkg::month_t  set_month;
  rtc_cal_pkg::day_t    set_day;
  rtc_cal_pkg::hour_t   set_hour;
  rtc_cal_pkg::minute_t set_minute;
  rtc_cal_pkg::second_t set_second;

  modport source (
    output valid, mode, set_year, set_month, set_day, set_hour, set_minute, set_second,
    input  ready
  );
  modport sink (
    input  valid, mode, set_year, set_month, set_day, set_hour, set_minute, set_second,
    output ready
  );
endinterface

interface rtc_cal_out_if;
  logic                valid;
  logic                ready;
  rtc_cal_pkg::second_t now_second;
  rtc_cal_pkg::minute_t now_minute;
  rtc_cal_pkg::hour_t   now_hour;
  rtc_cal_pkg::day_t    now_day;
  rtc_cal_pkg::month_t  now_month;
  rtc_cal_pkg::year_t   now_year;
  rtc_cal_pkg::wday_t   weekday;
  rtc_cal_pkg::yday_t   year_day;
  logic                leap_flag;
  logic                load_refused;

  modport source (
    output valid, now_second, now_minute, now_hour, now_day, now_month, now_year,
           weekday, year_day, leap_flag, load_refused,
    input  ready
  );
  modport sink (
    input  valid, now_second, now_minute, now_hour, now_day, now_month, now_year,
           weekday, year_day, leap_flag, load_refused,
    output ready
  );
endinterface

`default_nettype wire

/* sv/rtc_cal_counter.sv */
// Input register and time/date counters: one tick or load per beat.
// Depends on rtc_cal_pkg and rtc_cal_in_if.
`default_nettype none

module rtc_cal_counter (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  rtc_cal_in_if.sink               in_i,
  output rtc_cal_pkg::snap_t       snap_o,
  input  logic                     snap_ready_i,
  output rtc_cal_pkg::stage_stat_t stat_o
);

  logic                 in_vld_q;
  logic                 mode_q;
  rtc_cal_pkg::year_t   sy_q;
  rtc_cal_pkg::month_t  smo_q;
  rtc_cal_pkg::day_t    sd_q;
  rtc_cal_pkg::hour_t   sh_q;
  rtc_cal_pkg::minute_t smi_q;
  rtc_cal_pkg::second_t ss_q;

  logic                   snap_vld_q;
  logic                   refused_q, refused_d;
  rtc_cal_pkg::calendar_t cnt_q, cnt_d;

  logic s1_ready;
  logic fire;
  logic load_ok;

  // Handshake: the counters advance only once the previous snapshot is taken
  assign s1_ready   = !snap_vld_q || snap_ready_i;
  assign fire       = in_vld_q && s1_ready;
  assign in_i.ready = !in_vld_q || s1_ready;

  // Input register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q <= 1'b0;
    end else if (in_i.ready) begin
      in_vld_q <= in_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_i.valid && in_i.ready) begin
      mode_q <= in_i.mode;
      sy_q   <= in_i.set_year;
      smo_q  <= in_i.set_month;
      sd_q   <= in_i.set_day;
      sh_q   <= in_i.set_hour;
      smi_q  <= in_i.set_minute;
      ss_q   <= in_i.set_second;
    end
  end

  // Legality of a load; day checked against the loaded month and year
  assign load_ok = (sy_q != '0) && (sy_q <= rtc_cal_pkg::YearW'(rtc_cal_pkg::MaxYear)) &&
                   (smo_q != '0) && (smo_q <= rtc_cal_pkg::MonthW'(rtc_cal_pkg::LastMonth)) &&
                   (sh_q <= rtc_cal_pkg::HourW'(rtc_cal_pkg::LastHour)) &&
                   (smi_q <= rtc_cal_pkg::MinW'(rtc_cal_pkg::LastMinute)) &&
                   (ss_q <= rtc_cal_pkg::SecW'(rtc_cal_pkg::LastSecond)) &&
                   (sd_q != '0) &&
                   (sd_q <= rtc_cal_pkg::month_len(smo_q, rtc_cal_pkg::is_leap(sy_q)));

  // Next counter state: load or one-second carry chain
  always_comb begin
    cnt_d     = cnt_q;
    refused_d = 1'b0;
    if (mode_q == rtc_cal_pkg::ModeLoad) begin
      if (load_ok) begin
        cnt_d.year   = sy_q;
        cnt_d.month  = smo_q;
        cnt_d.day    = sd_q;
        cnt_d.hour   = sh_q;
        cnt_d.minute = smi_q;
        cnt_d.second = ss_q;
      end else begin
        refused_d = 1'b1;
      end
    end else begin
      if (cnt_q.second != rtc_cal_pkg::SecW'(rtc_cal_pkg::LastSecond)) begin
        cnt_d.second = cnt_q.second + rtc_cal_pkg::SecW'(1);
      end else begin
        cnt_d.second = '0;
        if (cnt_q.minute != rtc_cal_pkg::MinW'(rtc_cal_pkg::LastMinute)) begin
          cnt_d.minute = cnt_q.minute + rtc_cal_pkg::MinW'(1);
        end else begin
          cnt_d.minute = '0;
          if (cnt_q.hour != rtc_cal_pkg::HourW'(rtc_cal_pkg::LastHour)) begin
            cnt_d.hour = cnt_q.hour + rtc_cal_pkg::HourW'(1);
          end else begin
            cnt_d.hour = '0;
            if (cnt_q.day < rtc_cal_pkg::month_len(cnt_q.month,
                                                   rtc_cal_pkg::is_leap(cnt_q.year))) begin
              cnt_d.day = cnt_q.day + rtc_cal_pkg::DayW'(1);
            end else begin
              cnt_d.day = rtc_cal_pkg::DayW'(1);
              if (cnt_q.month < rtc_cal_pkg::MonthW'(rtc_cal_pkg::LastMonth)) begin
                cnt_d.month = cnt_q.month + rtc_cal_pkg::MonthW'(1);
              end else begin
                cnt_d.month = rtc_cal_pkg::MonthW'(1);
                // year 9999 wraps to year 1
                cnt_d.year  = (cnt_q.year >= rtc_cal_pkg::YearW'(rtc_cal_pkg::MaxYear)) ?
                              rtc_cal_pkg::YearW'(1) : cnt_q.year + rtc_cal_pkg::YearW'(1);
              end
            end
          end
        end
      end
    end
  end

  // Counters double as the snapshot: they change only when the snapshot is free
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      snap_vld_q   <= 1'b0;
      cnt_q.year   <= rtc_cal_pkg::YearW'(rtc_cal_pkg::ResetYear);
      cnt_q.month  <= rtc_cal_pkg::MonthW'(rtc_cal_pkg::ResetMonth);
      cnt_q.day    <= rtc_cal_pkg::DayW'(rtc_cal_pkg::ResetDay);
      cnt_q.hour   <= rtc_cal_pkg::HourW'(rtc_cal_pkg::ResetHour);
      cnt_q.minute <= '0;
      cnt_q.second <= '0;
    end else begin
      if (s1_ready) begin
        snap_vld_q <= in_vld_q;
      end
      if (fire) begin
        cnt_q <= cnt_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (fire) begin
      refused_q <= refused_d;
    end
  end

  assign snap_o.vld     = snap_vld_q;
  assign snap_o.refused = refused_q;
  assign snap_o.cal     = cnt_q;

  assign stat_o.head_vld = in_vld_q;
  assign stat_o.tail_vld = snap_vld_q;

endmodule

`default_nettype wire

/* sv/rtc_cal_derive.sv */
// Weekday, day of year and leap flag from a date snapshot, two stages,
// ending in the result register. Depends on rtc_cal_pkg and rtc_cal_out_if.
`default_nettype none

module rtc_cal_derive (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  rtc_cal_pkg::snap_t       snap_i,
  output logic                     snap_ready_o,
  rtc_cal_out_if.source            out_o,
  output rtc_cal_pkg::stage_stat_t stat_o
);

  // Stage A registers
  logic                          mul_vld_q;
  rtc_cal_pkg::calendar_t        a_cal_q;
  logic                          a_refused_q;
  logic                          a_leap_q;
  logic [rtc_cal_pkg::Quot100W-1:0] a_q100_q;
  rtc_cal_pkg::year_t            a_yy_q;
  logic [rtc_cal_pkg::DdW-1:0]   a_dd_q;

  // Result registers
  logic                   out_vld_q;
  rtc_cal_pkg::calendar_t o_cal_q;
  rtc_cal_pkg::wday_t     o_wday_q;
  rtc_cal_pkg::yday_t     o_yday_q;
  logic                   o_leap_q;
  logic                   o_refused_q;

  logic a_ready, b_ready;
  logic before_mar;
  rtc_cal_pkg::year_t          yy_a;
  logic [rtc_cal_pkg::DdW-1:0] dd_a;
  logic [rtc_cal_pkg::ProdW-1:0] p_yy;

  logic [rtc_cal_pkg::DdW-1:0] wsum;
  logic [5:0]                  fold1;
  logic [3:0]                  fold2;
  logic [3:0]                  rem7;
  rtc_cal_pkg::wday_t          wday_b;
  rtc_cal_pkg::yday_t          yday_b;

  assign b_ready      = !out_vld_q || out_o.ready;
  assign a_ready      = !mul_vld_q || b_ready;
  assign snap_ready_o = a_ready;

  // Stage A: shift Jan/Feb into the previous year, divide by 100, leap rule
  assign before_mar = snap_i.cal.month < rtc_cal_pkg::MonthW'(rtc_cal_pkg::Mar);
  assign yy_a = before_mar ? snap_i.cal.year - rtc_cal_pkg::YearW'(1) : snap_i.cal.year;
  assign dd_a = before_mar ?
                rtc_cal_pkg::DdW'(snap_i.cal.day) + rtc_cal_pkg::DdW'(snap_i.cal.year) :
                rtc_cal_pkg::DdW'(snap_i.cal.day) + rtc_cal_pkg::DdW'(snap_i.cal.year)
                - rtc_cal_pkg::DdW'(2);
  assign p_yy = rtc_cal_pkg::mul_recip100(yy_a);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mul_vld_q <= 1'b0;
    end else if (a_ready) begin
      mul_vld_q <= snap_i.vld;
    end
  end

  always_ff @(posedge clk_i) begin
    if (a_ready && snap_i.vld) begin
      a_cal_q     <= snap_i.cal;
      a_refused_q <= snap_i.refused;
      a_leap_q    <= rtc_cal_pkg::is_leap(snap_i.cal.year);
      a_q100_q    <= p_yy[rtc_cal_pkg::ProdW-1:rtc_cal_pkg::Recip100Shift];
      a_yy_q      <= yy_a;
      a_dd_q      <= dd_a;
    end
  end

  // Stage B: weekday sum, mod 7 by folding octal digits (8 = 1 mod 7)
  assign wsum = rtc_cal_pkg::DdW'(rtc_cal_pkg::month_offset(a_cal_q.month)) + a_dd_q
              + rtc_cal_pkg::DdW'(4) + rtc_cal_pkg::DdW'(a_yy_q >> 2)
              - rtc_cal_pkg::DdW'(a_q100_q) + rtc_cal_pkg::DdW'(a_q100_q >> 2);
  assign fold1 = 6'(wsum[14:12]) + 6'(wsum[11:9]) + 6'(wsum[8:6])
               + 6'(wsum[5:3]) + 6'(wsum[2:0]);
  assign fold2 = 4'(fold1[5:3]) + 4'(fold1[2:0]);
  assign rem7  = (fold2 >= 4'd7) ? fold2 - 4'd7 : fold2;
  // remainder 0 is Sunday
  assign wday_b = (rem7 == 4'd0) ? rtc_cal_pkg::WdayW'(7) : rem7[rtc_cal_pkg::WdayW-1:0];

  // Day of year: days before the month, leap day after February, day of month
  assign yday_b = rtc_cal_pkg::cum_days(a_cal_q.month)
                + rtc_cal_pkg::YdayW'(a_leap_q &&
                                      (a_cal_q.month > rtc_cal_pkg::MonthW'(rtc_cal_pkg::Feb)))
                + rtc_cal_pkg::YdayW'(a_cal_q.day);

  // Result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else if (b_ready) begin
      out_vld_q <= mul_vld_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (b_ready && mul_vld_q) begin
      o_cal_q     <= a_cal_q;
      o_wday_q    <= wday_b;
      o_yday_q    <= yday_b;
      o_leap_q    <= a_leap_q;
      o_refused_q <= a_refused_q;
    end
  end

  assign out_o.valid        = out_vld_q;
  assign out_o.now_second   = o_cal_q.second;
  assign out_o.now_minute   = o_cal_q.minute;
  assign out_o.now_hour     = o_cal_q.hour;
  assign out_o.now_day      = o_cal_q.day;
  assign out_o.now_month    = o_cal_q.month;
  assign out_o.now_year     = o_cal_q.year;
  assign out_o.weekday      = o_wday_q;
  assign out_o.year_day     = o_yday_q;
  assign out_o.leap_flag    = o_leap_q;
  assign out_o.load_refused = o_refused_q;

  assign stat_o.head_vld = mul_vld_q;
  assign stat_o.tail_vld = out_vld_q;

endmodule

`default_nettype wire

/* sv/rtc_calendar_counter_core.sv */
// Top level of the RTC calendar counter: counter stage and derive stages.
// Depends on rtc_cal_pkg, rtc_cal_if.sv, rtc_cal_counter, rtc_cal_derive, assert_macros.svh.
`default_nettype none
`include "assert_macros.svh"

// Real-time clock with a Gregorian calendar. Each input beat is a one-second
// tick (mode 0) or a load of the full time and date (mode 1); every beat gives
// exactly one result beat with the time and date after it, the weekday
// (1 Monday .. 7 Sunday), the day of year, the leap flag and, for a load with
// any illegal field, load_refused with the time and date unchanged. After reset
// the clock reads 12:00:00 on 1 January 2000. The block takes one beat per
// cycle while the output is not stalled. A beat passes four registers: input
// register, counter register, weekday/leap stage, result register, from which
// its result leaves. The rate is set by the counter register, which applies
// one tick or load per cycle unless stalled. A stage moves on whenever the one
// after it is empty or being emptied, so with the output stalled up to three
// further input beats are taken before the input stops.
module rtc_calendar_counter_core (
  input  logic          clk_i,
  input  logic          rst_ni,
  rtc_cal_in_if.sink    in_i,
  rtc_cal_out_if.source out_o
);

  rtc_cal_pkg::snap_t       snap;
  logic                     snap_ready;
  rtc_cal_pkg::stage_stat_t cnt_stat;
  rtc_cal_pkg::stage_stat_t drv_stat;

  logic in_beat;
  logic input_vld;
  logic stage_a_vld;
  logic result_vld;
  logic result_in_range;

  rtc_cal_counter u_counter (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_i         (in_i),
    .snap_o       (snap),
    .snap_ready_i (snap_ready),
    .stat_o       (cnt_stat)
  );

  rtc_cal_derive u_derive (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .snap_i       (snap),
    .snap_ready_o (snap_ready),
    .out_o        (out_o),
    .stat_o       (drv_stat)
  );

  // Signals watched by the checks
  assign in_beat         = in_i.valid && in_i.ready;
  assign input_vld       = cnt_stat.head_vld;
  assign stage_a_vld     = drv_stat.head_vld;
  assign result_vld      = drv_stat.tail_vld;
  assign result_in_range = (out_o.weekday != 3'd0) &&
                           ((out_o.year_day <= 9'd365) ||
                            (out_o.leap_flag && (out_o.year_day == 9'd366)));

  // Checks
  `RTC_ASSERT(a_accept_fills_input, in_beat |=> input_vld, "accepted beat not held")
  `RTC_ASSERT(a_empty_input_ready, !input_vld |-> in_i.ready, "input register empty, not ready")
  `RTC_ASSERT(a_result_from_stage, $rose(result_vld) |-> $past(stage_a_vld), "result from nowhere")
  `RTC_ASSERT(a_result_ranges, result_vld |-> result_in_range, "weekday or day of year out of range")

endmodule

`default_nettype wire
